[design/nol_pkg.sv]
// ----------------------------------------------------------------------------
// nol_pkg - newline offset line index, shared definitions
// Operation codes, table geometry and field widths of the line index core.
// ----------------------------------------------------------------------------
package nol_pkg;

  // table geometry
  localparam int MAX_NEWLINES = 1024;
  localparam int OFFSET_BITS  = 32;

  // derived widths
  localparam int ADDR_W = $clog2(MAX_NEWLINES);      // table address
  localparam int IDX_W  = $clog2(MAX_NEWLINES + 2);  // count, search bounds, line
  localparam int LEN_W  = OFFSET_BITS + 1;           // buffer length, range ends

  // request field widths
  localparam int OP_W     = 2;
  localparam int BYTE_W   = 8;
  localparam int QOFF_W   = 32;
  localparam int LNUM_W   = 32;
  localparam int COL_W    = 32;
  localparam int S_DATA_W = 72;   // byte, offset, line number, padded to bytes
  localparam int M_DATA_W = 112;  // line, column, start, end, overflow, padded

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;

  // request kinds
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR      = 2'd0,
    OP_APPEND     = 2'd1,
    OP_QUERY_OFF  = 2'd2,
    OP_QUERY_LINE = 2'd3
  } op_e;

endpackage

[design/newline_offset_line_index_core.sv]
// ----------------------------------------------------------------------------
// newline_offset_line_index_core - newline offset table with line lookup
// Records newline offsets of a streamed text buffer in an on-chip table and
// answers offset-to-line and line-to-range queries by binary search.
// ----------------------------------------------------------------------------
//
//  channel   | group        | dir | contents
//  ----------+--------------+-----+--------------------------------------------
//  request   | s_axis_*     | in  | tuser: op; tdata: byte, offset, line number
//  result    | m_axis_*     | out | tuser: line_valid; tdata: line, column,
//            |              |     |   range start, range end, overflow flag
//
//  Clear and append are taken back to back.
//  An offset query runs a lower-bound search of at most ceil(log2(count+1))
//  steps: each step is one read of the single-ported table followed by a
//  compare of the read data, then ST_PREV, ST_NEXT and ST_DONE follow.
//  A line query runs ST_PREV, ST_NEXT and ST_DONE, a bad line number ST_DONE only.
//  Reset is asynchronous; the table itself is not cleared (no clearing pass).
//  A held result stalls only the next query, in its ST_DONE state; appends and
//  clears are still taken while the result waits.
//
module newline_offset_line_index_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [7:0] data_byte, [39:8] query_offset, [71:40] line_number
  input  logic [nol_pkg::S_DATA_W-1:0]  s_axis_tdata_i,
  // [1:0] op
  input  logic [nol_pkg::OP_W-1:0]      s_axis_tuser_i,
  // result channel
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [10:0] line, [42:11] column, [75:43] range_start, [108:76] range_end,
  // [109] table_overflow, [111:110] zero
  output logic [nol_pkg::M_DATA_W-1:0]  m_axis_tdata_o,
  // [0] line_valid
  output logic                          m_axis_tuser_o
);

  localparam int AddrW = nol_pkg::ADDR_W;
  localparam int IdxW  = nol_pkg::IDX_W;
  localparam int LenW  = nol_pkg::LEN_W;
  localparam int OffW  = nol_pkg::OFFSET_BITS;
  localparam int QoffW = nol_pkg::QOFF_W;
  localparam int LnumW = nol_pkg::LNUM_W;
  localparam int ColW  = nol_pkg::COL_W;
  localparam int MaxNl = nol_pkg::MAX_NEWLINES;
  localparam int Depth = nol_pkg::MAX_NEWLINES;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_CMP,
    ST_PREV,
    ST_NEXT,
    ST_DONE
  } state_e;

  // request fields
  nol_pkg::op_e             req_op;
  logic [nol_pkg::BYTE_W-1:0] req_byte;
  logic [QoffW-1:0]         req_qoff;
  logic [LnumW-1:0]         req_lnum;
  logic                     req_fire;

  // control and working registers
  state_e            state_q, state_d;
  logic [IdxW-1:0]   count_q, count_d;
  logic [LenW-1:0]   len_q, len_d;
  logic              ovf_q, ovf_d;
  logic [IdxW-1:0]   lo_q, lo_d;
  logic [IdxW-1:0]   hi_q, hi_d;
  logic [QoffW-1:0]  qoff_q, qoff_d;
  logic              is_off_q, is_off_d;
  logic              inval_q, inval_d;
  logic [LenW-1:0]   start_q, start_d;

  // result register
  logic              m_valid_q, m_valid_d;
  logic [IdxW-1:0]   line_q, line_d;
  logic [ColW-1:0]   col_q, col_d;
  logic [LenW-1:0]   rstart_q, rstart_d;
  logic [LenW-1:0]   rend_q, rend_d;
  logic              lvalid_q, lvalid_d;
  logic              tovf_q, tovf_d;

  // table port
  logic [OffW-1:0]   mem [Depth];
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [OffW-1:0]   wr_data;
  logic              rd_en;
  logic [AddrW-1:0]  rd_addr;
  logic [OffW-1:0]   rd_data_q;

  // datapath helpers
  logic [IdxW-1:0]   mid;
  logic [IdxW-1:0]   idx_m1;
  logic [LenW-1:0]   end_val;
  logic [ColW+1:0]   col_full;
  logic [ColW-1:0]   col_sat;
  logic              out_free;
  logic              lnum_ok;

  // unpack request
  assign req_op   = nol_pkg::op_e'(s_axis_tuser_i);
  assign req_byte = s_axis_tdata_i[7:0];
  assign req_qoff = s_axis_tdata_i[39:8];
  assign req_lnum = s_axis_tdata_i[71:40];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign req_fire        = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  // search midpoint and neighbour index
  assign mid    = lo_q + ((hi_q - lo_q) >> 1);
  assign idx_m1 = lo_q - IdxW'(1);

  // line number in range 1 .. count+1
  assign lnum_ok = (req_lnum != '0) &&
                   (req_lnum <= (LnumW'(count_q) + LnumW'(1)));

  // end of line: next newline, or buffer length for the last line
  assign end_val = (lo_q >= count_q) ? len_q : LenW'(rd_data_q);

  // 1-based column, clipped to the column field
  assign col_full = (ColW+2)'(qoff_q) + (ColW+2)'(1) - (ColW+2)'(start_q);
  always_comb begin
    if (LenW'(qoff_q) < start_q) begin
      col_sat = '0;
    end else if (col_full[ColW+1:ColW] != 2'b00) begin
      col_sat = '1;
    end else begin
      col_sat = col_full[ColW-1:0];
    end
  end

  // next-state logic
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    len_d     = len_q;
    ovf_d     = ovf_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    qoff_d    = qoff_q;
    is_off_d  = is_off_q;
    inval_d   = inval_q;
    start_d   = start_q;
    m_valid_d = m_valid_q;
    line_d    = line_q;
    col_d     = col_q;
    rstart_d  = rstart_q;
    rend_d    = rend_q;
    lvalid_d  = lvalid_q;
    tovf_d    = tovf_q;
    wr_en     = 1'b0;
    wr_addr   = count_q[AddrW-1:0];
    wr_data   = len_q[OffW-1:0];
    rd_en     = 1'b0;
    rd_addr   = '0;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          unique case (req_op)
            nol_pkg::OP_CLEAR: begin
              count_d = '0;
              len_d   = '0;
              ovf_d   = 1'b0;
            end
            nol_pkg::OP_APPEND: begin
              // bytes past the largest offset are dropped
              if (!len_q[LenW-1]) begin
                len_d = len_q + LenW'(1);
                if (req_byte == nol_pkg::NEWLINE_BYTE) begin
                  if (count_q < IdxW'(MaxNl)) begin
                    wr_en   = 1'b1;
                    count_d = count_q + IdxW'(1);
                  end else begin
                    ovf_d = 1'b1;
                  end
                end
              end
            end
            nol_pkg::OP_QUERY_OFF: begin
              lo_d     = '0;
              hi_d     = count_q;
              qoff_d   = req_qoff;
              is_off_d = 1'b1;
              inval_d  = 1'b0;
              state_d  = ST_SRCH;
            end
            nol_pkg::OP_QUERY_LINE: begin
              is_off_d = 1'b0;
              if (lnum_ok) begin
                lo_d    = IdxW'(req_lnum - LnumW'(1));
                inval_d = 1'b0;
                state_d = ST_PREV;
              end else begin
                inval_d = 1'b1;
                state_d = ST_DONE;
              end
            end
          endcase
        end
      end

      // lower-bound search: read the midpoint
      ST_SRCH: begin
        if (lo_q < hi_q) begin
          rd_en   = 1'b1;
          rd_addr = mid[AddrW-1:0];
          state_d = ST_CMP;
        end else begin
          state_d = ST_PREV;
        end
      end

      // narrow the bounds on the read entry
      ST_CMP: begin
        if (LenW'(rd_data_q) < LenW'(qoff_q)) begin
          lo_d = mid + IdxW'(1);
        end else begin
          hi_d = mid;
        end
        state_d = ST_SRCH;
      end

      // fetch the newline before the line
      ST_PREV: begin
        if (lo_q != '0) begin
          rd_en   = 1'b1;
          rd_addr = idx_m1[AddrW-1:0];
        end
        state_d = ST_NEXT;
      end

      // line start, then fetch the newline that ends it
      ST_NEXT: begin
        start_d = (lo_q == '0) ? '0 : LenW'(rd_data_q) + LenW'(1);
        if (lo_q < count_q) begin
          rd_en   = 1'b1;
          rd_addr = lo_q[AddrW-1:0];
        end
        state_d = ST_DONE;
      end

      // load the result register once it is free
      ST_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          tovf_d    = ovf_q;
          if (inval_q) begin
            line_d   = '0;
            col_d    = '0;
            rstart_d = '0;
            rend_d   = '0;
            lvalid_d = 1'b0;
          end else begin
            line_d   = is_off_q ? (lo_q + IdxW'(1)) : '0;
            col_d    = is_off_q ? col_sat : '0;
            rstart_d = start_q;
            rend_d   = end_val;
            lvalid_d = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      len_q     <= '0;
      ovf_q     <= 1'b0;
      lo_q      <= '0;
      hi_q      <= '0;
      qoff_q    <= '0;
      is_off_q  <= 1'b0;
      inval_q   <= 1'b0;
      start_q   <= '0;
      m_valid_q <= 1'b0;
      line_q    <= '0;
      col_q     <= '0;
      rstart_q  <= '0;
      rend_q    <= '0;
      lvalid_q  <= 1'b0;
      tovf_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      len_q     <= len_d;
      ovf_q     <= ovf_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      qoff_q    <= qoff_d;
      is_off_q  <= is_off_d;
      inval_q   <= inval_d;
      start_q   <= start_d;
      m_valid_q <= m_valid_d;
      line_q    <= line_d;
      col_q     <= col_d;
      rstart_q  <= rstart_d;
      rend_q    <= rend_d;
      lvalid_q  <= lvalid_d;
      tovf_q    <= tovf_d;
    end
  end

  // newline table: one write or one read per cycle, never both in one state
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // pack result
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = lvalid_q;
  assign m_axis_tdata_o  = {2'b00, tovf_q, rend_q, rstart_q, col_q, line_q};

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= IdxW'(MaxNl))
    else $error("newline count above table size");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (count_q == IdxW'(MaxNl)))
    else $error("overflow flagged with room left in table");

  a_search_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRCH || state_q == ST_CMP) |-> (lo_q <= hi_q && hi_q <= count_q))
    else $error("search bounds out of order");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the final query state");

  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == ST_IDLE && !rd_en))
    else $error("table write outside idle or alongside a read");

endmodule

[sim/nol_result_checker.sv]
// ----------------------------------------------------------------------------
// nol_result_checker - result checker for the newline offset line index
// Watches the request and result streams of the core. It keeps its own copy
// of the newline table, the line count, the buffer length and the overflow
// flag, works out the answer to every accepted query, and compares each
// returned result field by field with the oldest answer still owed.
// ----------------------------------------------------------------------------
module nol_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel, as seen on the wires
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_i,
  // [7:0] data_byte, [39:8] query_offset, [71:40] line_number
  input  logic [nol_pkg::S_DATA_W-1:0]  s_axis_tdata_i,
  // [1:0] op
  input  logic [nol_pkg::OP_W-1:0]      s_axis_tuser_i,
  // result channel
  input  logic                          m_axis_tvalid_i,
  input  logic                          m_axis_tready_i,
  // [10:0] line, [42:11] column, [75:43] range_start, [108:76] range_end,
  // [109] table_overflow, [111:110] zero
  input  logic [nol_pkg::M_DATA_W-1:0]  m_axis_tdata_i,
  // [0] line_valid
  input  logic                          m_axis_tuser_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            checked_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [nol_pkg::IDX_W-1:0] line;
    logic [nol_pkg::COL_W-1:0] column;
    logic [nol_pkg::LEN_W-1:0] range_start;
    logic [nol_pkg::LEN_W-1:0] range_end;
    logic                      line_valid;
    logic                      table_overflow;
  } line_answer_t;

  // local copy of the index state
  logic [nol_pkg::OFFSET_BITS-1:0] nl_offset [nol_pkg::MAX_NEWLINES];
  logic [nol_pkg::IDX_W-1:0]       nl_count;
  logic [nol_pkg::LEN_W-1:0]       text_len;
  logic                            overflow_seen;

  // answers owed, oldest first
  line_answer_t expected_answers [$];
  line_answer_t want, got;
  nol_pkg::op_e req_op;

  // answer to an offset or line query from the current state
  function automatic line_answer_t answer_query(nol_pkg::op_e op,
                                                logic [nol_pkg::QOFF_W-1:0] qoff,
                                                logic [nol_pkg::LNUM_W-1:0] lnum);
    line_answer_t a;
    int           lo, hi, mid, n;
    logic [63:0]  col;
    a = '0;
    a.table_overflow = overflow_seen;
    if (op == nol_pkg::OP_QUERY_OFF) begin
      // lower bound: first stored newline at or past the offset
      lo = 0;
      hi = int'(nl_count);
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (nl_offset[mid] < qoff) lo = mid + 1;
        else hi = mid;
      end
      a.line        = nol_pkg::IDX_W'(lo + 1);
      a.range_start = (lo == 0) ? '0 : {1'b0, nl_offset[lo-1]} + 33'd1;
      a.range_end   = (lo >= int'(nl_count)) ? text_len : {1'b0, nl_offset[lo]};
      col = ({32'b0, qoff} >= {31'b0, a.range_start}) ?
            {32'b0, qoff} - {31'b0, a.range_start} + 64'd1 : 64'd0;
      // column saturates at the top of its range
      a.column     = (col > 64'hFFFF_FFFF) ? '1 : col[nol_pkg::COL_W-1:0];
      a.line_valid = 1'b1;
    end else if (lnum != '0 && {32'b0, lnum} <= {53'b0, nl_count} + 64'd1) begin
      n = int'(lnum);
      a.range_start = (n == 1) ? '0 : {1'b0, nl_offset[n-2]} + 33'd1;
      a.range_end   = (n - 1 < int'(nl_count)) ? {1'b0, nl_offset[n-1]} : text_len;
      a.line_valid  = 1'b1;
    end
    return a;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nl_count      = '0;
      text_len      = '0;
      overflow_seen = 1'b0;
      expected_answers.delete();
      pending_o     = 0;
      checked_o     = 0;
    end else begin
      // returned result against the oldest owed answer
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.line           = m_axis_tdata_i[10:0];
        got.column         = m_axis_tdata_i[42:11];
        got.range_start    = m_axis_tdata_i[75:43];
        got.range_end      = m_axis_tdata_i[108:76];
        got.table_overflow = m_axis_tdata_i[109];
        got.line_valid     = m_axis_tuser_i;
        if (expected_answers.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        end else begin
          want = expected_answers.pop_front();
          check_field("line", want.line, got.line);
          check_field("column", want.column, got.column);
          check_field("range_start", want.range_start, got.range_start);
          check_field("range_end", want.range_end, got.range_end);
          check_field("line_valid", want.line_valid, got.line_valid);
          check_field("table_overflow", want.table_overflow, got.table_overflow);
          checked_o++;
        end
      end

      // accepted request updates the state or owes an answer
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        req_op = nol_pkg::op_e'(s_axis_tuser_i);
        case (req_op)
          nol_pkg::OP_CLEAR: begin
            nl_count      = '0;
            text_len      = '0;
            overflow_seen = 1'b0;
          end
          nol_pkg::OP_APPEND: begin
            // a full buffer ignores the byte entirely
            if (text_len < {1'b1, {nol_pkg::OFFSET_BITS{1'b0}}}) begin
              if (s_axis_tdata_i[7:0] == nol_pkg::NEWLINE_BYTE) begin
                if (nl_count < nol_pkg::MAX_NEWLINES) begin
                  nl_offset[nl_count] = text_len[nol_pkg::OFFSET_BITS-1:0];
                  nl_count++;
                end else begin
                  overflow_seen = 1'b1;
                end
              end
              text_len++;
            end
          end
          default: begin
            expected_answers.insert(expected_answers.size(),
                                    answer_query(req_op, s_axis_tdata_i[39:8],
                                                 s_axis_tdata_i[71:40]));
          end
        endcase
      end
      pending_o = expected_answers.size();
    end
  end

endmodule

[sim/tb_newline_offset_line_index_core.sv]
// ----------------------------------------------------------------------------
// tb_newline_offset_line_index_core - testbench of the line index core
// Builds short texts byte by byte and fires offset and line queries at them,
// first a directed set around empty buffers, empty lines and the edges of the
// offset range, then random sessions under four mixes of sender idling and
// receiver stalls. Results are checked by the checker module beside the core.
// ----------------------------------------------------------------------------
module tb_newline_offset_line_index_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT   = 2000;  // cycles with no transfer at all
  localparam int SETTLE_CYCLES = 64;
  localparam int PHASE_ITEMS   = 170;

  logic                         clk      = 1'b0;
  logic                         rst_n    = 1'b0;
  logic                         s_tvalid = 1'b0;
  logic [nol_pkg::S_DATA_W-1:0] s_tdata  = '0;
  logic [nol_pkg::OP_W-1:0]     s_tuser  = '0;
  logic                         m_tready = 1'b0;
  wire                          s_tready;
  wire                          m_tvalid;
  wire [nol_pkg::M_DATA_W-1:0]  m_tdata;
  wire                          m_tuser;

  int fail_count, pending, checked;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int req_count    = 0;
  int stuck_cycles = 0;

  // rough view of the text, only to aim queries
  logic [nol_pkg::LEN_W-1:0] text_len_seen = '0;
  int                        newlines_seen = 0;

  always #5 clk = ~clk;

  newline_offset_line_index_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  nol_result_checker u_result_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  // result side back-pressure
  always @(posedge clk) begin
    m_tready <= (rx_stall_pct == 0) || ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // watchdog: too long without any transfer
  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STALL_LIMIT) begin
      $display("FAIL newline_offset_line_index_core");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // one request, with random idle cycles ahead of it
  task automatic send_req(nol_pkg::op_e op, logic [nol_pkg::BYTE_W-1:0] b,
                          logic [nol_pkg::QOFF_W-1:0] q, logic [nol_pkg::LNUM_W-1:0] n);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {n, q, b};
    // tready is settled by the falling edge; the transfer is the next rise
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    req_count++;
    if (op == nol_pkg::OP_CLEAR) begin
      text_len_seen = '0;
      newlines_seen = 0;
    end else if (op == nol_pkg::OP_APPEND) begin
      text_len_seen++;
      if (b == nol_pkg::NEWLINE_BYTE) newlines_seen++;
    end
  endtask

  // queries aimed mostly at the current text, some noise between
  task automatic query_burst(int count);
    int                         pick, r, lines;
    logic [nol_pkg::QOFF_W-1:0] off;
    logic [nol_pkg::LNUM_W-1:0] lnum;
    repeat (count) begin
      pick  = $urandom_range(0, 99);
      r     = $urandom_range(0, 9);
      lines = (newlines_seen < nol_pkg::MAX_NEWLINES) ? newlines_seen
                                                      : nol_pkg::MAX_NEWLINES;
      if (pick < 50) begin
        if (r < 7) off = $urandom_range(0, 32'(text_len_seen) + 2);
        else if (r < 8) off = 32'(text_len_seen) + $urandom_range(0, 1000);
        else if (r < 9) off = 32'hFFFF_FFFF - $urandom_range(0, 3);
        else off = $urandom;
        send_req(nol_pkg::OP_QUERY_OFF, 8'($urandom), off, $urandom);
      end else if (pick < 90) begin
        if (r < 8) lnum = $urandom_range(0, lines + 2);
        else if (r < 9) lnum = 32'hFFFF_FFFF;
        else lnum = $urandom;
        send_req(nol_pkg::OP_QUERY_LINE, 8'($urandom), $urandom, lnum);
      end else begin
        send_req(nol_pkg::op_e'($urandom_range(0, 3)), 8'($urandom), $urandom, $urandom);
      end
    end
  endtask

  // one text: usually fresh, some bytes, then queries
  task automatic text_session();
    int len, nl_pct;
    if ($urandom_range(0, 4) != 0) begin
      send_req(nol_pkg::OP_CLEAR, 8'($urandom), $urandom, $urandom);
    end
    len    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 24);
    nl_pct = $urandom_range(5, 40);
    repeat (len) begin
      send_req(nol_pkg::OP_APPEND,
               ($urandom_range(0, 99) < nl_pct) ? nol_pkg::NEWLINE_BYTE : 8'($urandom),
               $urandom, $urandom);
    end
    query_burst($urandom_range(2, 10));
  endtask

  initial begin
    int ph, start;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty buffer: one line, saturating column at the top offset
    send_req(nol_pkg::OP_QUERY_OFF, 8'h00, 32'd0, 32'd0);
    send_req(nol_pkg::OP_QUERY_OFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(nol_pkg::OP_QUERY_LINE, 8'h00, 32'd0, 32'd0);
    send_req(nol_pkg::OP_QUERY_LINE, 8'h00, 32'd0, 32'd1);
    send_req(nol_pkg::OP_QUERY_LINE, 8'h00, 32'd0, 32'd2);
    send_req(nol_pkg::OP_QUERY_LINE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // text "\n", 'a', 0xFF, 0x00, "\n", "\n": leading newline and an empty line
    send_req(nol_pkg::OP_APPEND, nol_pkg::NEWLINE_BYTE, 32'd0, 32'd0);
    send_req(nol_pkg::OP_APPEND, 8'h61, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(nol_pkg::OP_APPEND, 8'hFF, 32'd0, 32'd0);
    send_req(nol_pkg::OP_APPEND, 8'h00, 32'd0, 32'd0);
    send_req(nol_pkg::OP_APPEND, nol_pkg::NEWLINE_BYTE, 32'd0, 32'd0);
    send_req(nol_pkg::OP_APPEND, nol_pkg::NEWLINE_BYTE, 32'd0, 32'd0);
    // offsets on a newline, just after, at the end, past the end
    send_req(nol_pkg::OP_QUERY_OFF, 8'h00, 32'd0, 32'd0);
    send_req(nol_pkg::OP_QUERY_OFF, 8'h00, 32'd1, 32'd0);
    send_req(nol_pkg::OP_QUERY_OFF, 8'h00, 32'd5, 32'd0);
    send_req(nol_pkg::OP_QUERY_OFF, 8'h00, 32'd6, 32'd0);
    send_req(nol_pkg::OP_QUERY_OFF, 8'h00, 32'd100, 32'd0);
    send_req(nol_pkg::OP_QUERY_OFF, 8'h00, 32'hFFFF_FFFF, 32'd0);
    send_req(nol_pkg::OP_QUERY_LINE, 8'h00, 32'd0, 32'd1);
    send_req(nol_pkg::OP_QUERY_LINE, 8'h00, 32'd0, 32'd3);
    send_req(nol_pkg::OP_QUERY_LINE, 8'h00, 32'd0, 32'd4);
    send_req(nol_pkg::OP_QUERY_LINE, 8'h00, 32'd0, 32'd5);
    // clear goes back to a single empty line
    send_req(nol_pkg::OP_CLEAR, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(nol_pkg::OP_QUERY_LINE, 8'h00, 32'd0, 32'd1);

    // random sessions under each idle/stall mix
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct = 48; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct <= 48; end
        default: begin tx_idle_pct = 11; rx_stall_pct <= 11; end
      endcase
      start = req_count;
      while (req_count - start < PHASE_ITEMS) text_session();
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d requests in four idle/stall mixes, %0d answers compared.",
             req_count, checked);
    $display("Included empty lines, past-end offsets, column saturation, bad line numbers.");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS newline_offset_line_index_core");
    end else begin
      $display("FAIL newline_offset_line_index_core");
    end
    $finish;
  end

endmodule
